// File: design/ptts_pkg.sv
package ptts_pkg;

  localparam int NUM_TASKS    = 8;
  localparam int PERIOD_WIDTH = 16;

  localparam int SLOT_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int CNT_W  = $clog2(NUM_TASKS + 1);

  typedef logic [SLOT_W-1:0]       slot_t;
  typedef logic [CNT_W-1:0]        cnt_t;
  typedef logic [PERIOD_WIDTH-1:0] period_t;

  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_CREATE  = 3'd1,
    OP_START   = 3'd2,
    OP_STOP    = 3'd3,
    OP_CHANGE  = 3'd4,
    OP_SERVICE = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TICK,
    ST_SERV
  } state_e;

  localparam logic STATUS_DONE    = 1'b0;
  localparam logic STATUS_IGNORED = 1'b1;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [2:0]  task_id;
    logic [15:0] period;
  } req_t;

  typedef struct packed {
    logic       has_task;
    logic [2:0] task_id_out;
    logic       status;
    logic       last;
  } rsp_t;

endpackage

// File: design/ptts_ram.sv
module ptts_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: design/periodic_task_tick_scheduler.sv
// Periodic task tick scheduler.
// A request is taken at a rising edge with start high and busy low. Every
// request yields results on rsp_o, each shown for one cycle with rsp_valid_o
// high; the receiver cannot stall them. rsp_o.last marks the final result.
// Create, start, stop, change period and unused opcodes finish without a walk:
// their single result appears the cycle after the request and busy stays low.
// Tick walks the run list one slot per cycle through the period and timer
// memories (read, then compare and write back, overlapped); its result
// comes at the end, and an empty list answers at once. Service scans the
// run list one entry per cycle and emits each pending slot as it is found,
// or one result with has_task low if none is pending.
// busy is high while a tick or service walk runs.
// Reset clears all slots, the run list and the pending and active marks at
// once; valid bits make entries never written read as zero, so no clearing pass runs.
module periodic_task_tick_scheduler (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  input  ptts_pkg::req_t req_i,
  output logic           busy,
  output logic           rsp_valid_o,
  output ptts_pkg::rsp_t rsp_o
);

  import ptts_pkg::*;

  state_e  state_q, state_d;
  slot_t   order_q [NUM_TASKS];
  slot_t   order_d [NUM_TASKS];
  cnt_t    count_q, count_d;
  cnt_t    idx_q, idx_d;
  logic [NUM_TASKS-1:0] active_q, active_d;
  logic [NUM_TASKS-1:0] pending_q, pending_d;
  logic [NUM_TASKS-1:0] per_vld_q, per_vld_d;
  logic [NUM_TASKS-1:0] tmr_vld_q, tmr_vld_d;
  logic    s2_vld_q, s2_vld_d;
  slot_t   s2_slot_q, s2_slot_d;
  logic    sent_q, sent_d;
  logic    rsp_valid_q, rsp_valid_d;
  rsp_t    rsp_q, rsp_d;

  logic    per_we, tmr_we;
  slot_t   per_waddr, tmr_waddr, rd_addr;
  period_t per_wdata, tmr_wdata, per_rdata, tmr_rdata;

  logic    accept, ok_id, in_list, tick_done, serv_done, fire;
  op_e     op;
  slot_t   slot_in, cur_slot;
  period_t per_in, tmr_cur, per_cur;
  logic [NUM_TASKS-1:0] match, shift;

  assign accept    = start && (state_q == ST_IDLE);
  assign op        = op_e'(req_i.opcode);
  assign ok_id     = int'(req_i.task_id) < NUM_TASKS;
  assign slot_in   = SLOT_W'(req_i.task_id);
  assign per_in    = PERIOD_WIDTH'(req_i.period);
  assign in_list   = idx_q < count_q;
  assign cur_slot  = order_q[idx_q[SLOT_W-1:0]];
  assign tick_done = (state_q == ST_TICK) && !in_list && !s2_vld_q;
  assign serv_done = (state_q == ST_SERV) && !in_list;
  assign rd_addr   = cur_slot;

  assign tmr_cur = tmr_vld_q[s2_slot_q] ? tmr_rdata : '0;
  assign per_cur = per_vld_q[s2_slot_q] ? per_rdata : '0;
  assign fire    = tmr_cur >= per_cur;

  assign busy        = (state_q != ST_IDLE);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  // locate the slot in the run list and mark entries that shift down
  always_comb begin
    for (int j = 0; j < NUM_TASKS; j++) begin
      match[j] = (CNT_W'(j) < count_q) && (order_q[j] == slot_in);
    end
    shift[0] = match[0];
    for (int j = 1; j < NUM_TASKS; j++) begin
      shift[j] = shift[j-1] | match[j];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && op == OP_TICK && count_q != '0) begin
          state_d = ST_TICK;
        end else if (accept && op == OP_SERVICE && count_q != '0) begin
          state_d = ST_SERV;
        end
      end
      ST_TICK: begin
        if (tick_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_SERV: begin
        if (serv_done) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    order_d     = order_q;
    count_d     = count_q;
    idx_d       = idx_q;
    active_d    = active_q;
    pending_d   = pending_q;
    per_vld_d   = per_vld_q;
    tmr_vld_d   = tmr_vld_q;
    s2_vld_d    = 1'b0;
    s2_slot_d   = s2_slot_q;
    sent_d      = sent_q;
    rsp_valid_d = 1'b0;
    rsp_d       = rsp_q;
    per_we      = 1'b0;
    per_waddr   = slot_in;
    per_wdata   = per_in;
    tmr_we      = 1'b0;
    tmr_waddr   = s2_slot_q;
    tmr_wdata   = fire ? '0 : PERIOD_WIDTH'(tmr_cur + 1'b1);

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          idx_d       = '0;
          sent_d      = 1'b0;
          rsp_d       = '{has_task: 1'b0, task_id_out: 3'd0,
                          status: STATUS_DONE, last: 1'b1};
          rsp_valid_d = 1'b1;
          unique case (op)
            OP_TICK: begin
              rsp_valid_d = (count_q == '0);
            end
            OP_CREATE: begin
              if (ok_id) begin
                per_we             = 1'b1;
                per_vld_d[slot_in] = 1'b1;
                tmr_vld_d[slot_in] = 1'b0;
                pending_d[slot_in] = 1'b0;
              end else begin
                rsp_d.status = STATUS_IGNORED;
              end
            end
            OP_START: begin
              if (ok_id && !active_q[slot_in] && int'(count_q) < NUM_TASKS) begin
                for (int j = NUM_TASKS - 1; j > 0; j--) begin
                  order_d[j] = order_q[j-1];
                end
                order_d[0]        = slot_in;
                count_d           = count_q + 1'b1;
                active_d[slot_in] = 1'b1;
              end else begin
                rsp_d.status = STATUS_IGNORED;
              end
            end
            OP_STOP: begin
              if (ok_id) begin
                rsp_d.status = active_q[slot_in] ? STATUS_DONE : STATUS_IGNORED;
                if (match != '0) begin
                  for (int j = 0; j < NUM_TASKS - 1; j++) begin
                    if (shift[j]) begin
                      order_d[j] = order_q[j+1];
                    end
                  end
                  count_d = count_q - 1'b1;
                end
                active_d[slot_in]  = 1'b0;
                tmr_vld_d[slot_in] = 1'b0;
                pending_d[slot_in] = 1'b0;
              end else begin
                rsp_d.status = STATUS_IGNORED;
              end
            end
            OP_CHANGE: begin
              if (ok_id) begin
                per_we             = 1'b1;
                per_vld_d[slot_in] = 1'b1;
              end else begin
                rsp_d.status = STATUS_IGNORED;
              end
            end
            OP_SERVICE: begin
              rsp_valid_d = (count_q == '0);
            end
            default: begin
              rsp_d.status = STATUS_IGNORED;
            end
          endcase
        end
      end
      ST_TICK: begin
        if (in_list) begin
          s2_vld_d  = 1'b1;
          s2_slot_d = cur_slot;
          idx_d     = idx_q + 1'b1;
        end
        if (s2_vld_q) begin
          tmr_we               = 1'b1;
          tmr_vld_d[s2_slot_q] = 1'b1;
          if (fire) begin
            pending_d[s2_slot_q] = 1'b1;
          end
        end
        if (tick_done) begin
          rsp_valid_d = 1'b1;
        end
      end
      ST_SERV: begin
        if (in_list) begin
          idx_d = idx_q + 1'b1;
          if (pending_q[cur_slot]) begin
            pending_d[cur_slot] = 1'b0;
            sent_d              = 1'b1;
            rsp_valid_d         = 1'b1;
            rsp_d = '{has_task: 1'b1, task_id_out: 3'(cur_slot),
                      status: STATUS_DONE, last: ($countones(pending_q) == 1)};
          end
        end else if (!sent_q) begin
          rsp_valid_d = 1'b1;
          rsp_d       = '{has_task: 1'b0, task_id_out: 3'd0,
                          status: STATUS_DONE, last: 1'b1};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      active_q    <= '0;
      pending_q   <= '0;
      per_vld_q   <= '0;
      tmr_vld_q   <= '0;
      s2_vld_q    <= 1'b0;
      sent_q      <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      active_q    <= active_d;
      pending_q   <= pending_d;
      per_vld_q   <= per_vld_d;
      tmr_vld_q   <= tmr_vld_d;
      s2_vld_q    <= s2_vld_d;
      sent_q      <= sent_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    order_q   <= order_d;
    s2_slot_q <= s2_slot_d;
    rsp_q     <= rsp_d;
  end

  ptts_ram #(
    .WIDTH(PERIOD_WIDTH),
    .DEPTH(NUM_TASKS)
  ) u_period_ram (
    .clk_i  (clk_i),
    .we_i   (per_we),
    .waddr_i(per_waddr),
    .wdata_i(per_wdata),
    .raddr_i(rd_addr),
    .rdata_o(per_rdata)
  );

  ptts_ram #(
    .WIDTH(PERIOD_WIDTH),
    .DEPTH(NUM_TASKS)
  ) u_timer_ram (
    .clk_i  (clk_i),
    .we_i   (tmr_we),
    .waddr_i(tmr_waddr),
    .wdata_i(tmr_wdata),
    .raddr_i(rd_addr),
    .rdata_o(tmr_rdata)
  );

endmodule

// File: test/sched_rsp_checker.sv
`timescale 1ns / 1ps

module sched_rsp_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic           busy_i,
  input  ptts_pkg::req_t req_i,
  input  logic           rsp_valid_i,
  input  ptts_pkg::rsp_t rsp_i,
  output int             errors_o,
  output int             outstanding_o
);

  import ptts_pkg::*;

  period_t slot_per  [NUM_TASKS];
  period_t slot_tmr  [NUM_TASKS];
  logic    slot_pend [NUM_TASKS];
  logic    slot_act  [NUM_TASKS];
  slot_t   list_ids  [NUM_TASKS];
  int      list_len;
  rsp_t    sched_rsp_q[$];
  rsp_t    want;

  task automatic queue_rsp(input logic has, input slot_t id, input logic st, input logic lst);
    rsp_t r;
    r.has_task    = has;
    r.task_id_out = 3'(id);
    r.status      = st;
    r.last        = lst;
    sched_rsp_q.push_back(r);
  endtask

  task automatic schedule_step(input req_t r);
    int      i;
    int      n;
    int      found;
    logic    st;
    logic    id_ok;
    slot_t   s;
    slot_t   t;
    period_t per;
    slot_t   hits [NUM_TASKS];
    id_ok = r.task_id < NUM_TASKS;
    s     = slot_t'(r.task_id);
    per   = period_t'(r.period);
    st    = STATUS_DONE;
    if (r.opcode == OP_SERVICE) begin
      n = 0;
      for (i = 0; i < list_len; i++) begin
        t = list_ids[i];
        if (slot_pend[t]) begin
          slot_pend[t] = 1'b0;
          hits[n] = t;
          n++;
        end
      end
      if (n == 0) begin
        queue_rsp(1'b0, '0, STATUS_DONE, 1'b1);
      end else begin
        for (i = 0; i < n; i++) queue_rsp(1'b1, hits[i], STATUS_DONE, i == n - 1);
      end
    end else begin
      case (r.opcode)
        OP_TICK: begin
          for (i = 0; i < list_len; i++) begin
            t = list_ids[i];
            if (slot_tmr[t] >= slot_per[t]) begin
              slot_tmr[t]  = '0;
              slot_pend[t] = 1'b1;
            end else begin
              slot_tmr[t] = slot_tmr[t] + 1'b1;
            end
          end
        end
        OP_CREATE: begin
          if (id_ok) begin
            slot_per[s]  = per;
            slot_tmr[s]  = '0;
            slot_pend[s] = 1'b0;
          end else begin
            st = STATUS_IGNORED;
          end
        end
        OP_START: begin
          if (!id_ok || slot_act[s] || list_len >= NUM_TASKS) begin
            st = STATUS_IGNORED;
          end else begin
            for (i = list_len; i > 0; i--) list_ids[i] = list_ids[i-1];
            list_ids[0] = s;
            list_len++;
            slot_act[s] = 1'b1;
          end
        end
        OP_STOP: begin
          if (!id_ok) begin
            st = STATUS_IGNORED;
          end else begin
            found = -1;
            for (i = 0; i < list_len; i++) begin
              if (found < 0 && list_ids[i] == s) found = i;
            end
            if (found >= 0) begin
              for (i = found; i < list_len - 1; i++) list_ids[i] = list_ids[i+1];
              list_len--;
            end else begin
              st = STATUS_IGNORED;
            end
            slot_act[s]  = 1'b0;
            slot_tmr[s]  = '0;
            slot_pend[s] = 1'b0;
          end
        end
        OP_CHANGE: begin
          if (id_ok) slot_per[s] = per;
          else st = STATUS_IGNORED;
        end
        default: st = STATUS_IGNORED;
      endcase
      queue_rsp(1'b0, '0, st, 1'b1);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_TASKS; k++) begin
        slot_per[k]  = '0;
        slot_tmr[k]  = '0;
        slot_pend[k] = 1'b0;
        slot_act[k]  = 1'b0;
        list_ids[k]  = '0;
      end
      list_len = 0;
      sched_rsp_q.delete();
    end else begin
      if (rsp_valid_i) begin
        if (sched_rsp_q.size() == 0) begin
          if (errors_o < 10)
            $display("unexpected result: has=%0d id=%0d st=%0d last=%0d",
                     rsp_i.has_task, rsp_i.task_id_out, rsp_i.status, rsp_i.last);
          errors_o++;
        end else begin
          want = sched_rsp_q.pop_front();
          if (rsp_i.has_task !== want.has_task || rsp_i.task_id_out !== want.task_id_out ||
              rsp_i.status !== want.status || rsp_i.last !== want.last) begin
            if (errors_o < 10)
              $display("mismatch: want has=%0d id=%0d st=%0d last=%0d",
                       want.has_task, want.task_id_out, want.status, want.last,
                       ", got has=%0d id=%0d st=%0d last=%0d",
                       rsp_i.has_task, rsp_i.task_id_out, rsp_i.status, rsp_i.last);
            errors_o++;
          end
        end
      end
      if (start_i && !busy_i) schedule_step(req_i);
    end
    outstanding_o = sched_rsp_q.size();
  end

endmodule

// File: test/tb_periodic_task_tick_scheduler.sv
`timescale 1ns / 1ps

module tb_periodic_task_tick_scheduler;
  import ptts_pkg::*;

  localparam logic [2:0] OP_RSVD_LO = 3'd6;
  localparam logic [2:0] OP_RSVD_HI = 3'd7;
  localparam int IDLE_LIMIT = 2000;

  logic clk_i;
  logic rst_ni;
  logic start;
  req_t req_i;
  logic busy;
  logic rsp_valid_o;
  rsp_t rsp_o;
  int   errors;
  int   outstanding;
  int   idle_cycles;

  periodic_task_tick_scheduler u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .req_i      (req_i),
    .busy       (busy),
    .rsp_valid_o(rsp_valid_o),
    .rsp_o      (rsp_o)
  );

  sched_rsp_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .req_i        (req_i),
    .rsp_valid_i  (rsp_valid_o),
    .rsp_i        (rsp_o),
    .errors_o     (errors),
    .outstanding_o(outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || rsp_valid_o) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [15:0] pick_period();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return 16'($urandom_range(0, 3));
    if (r < 92) return 16'($urandom_range(0, 20));
    return 16'($urandom);
  endfunction

  function automatic logic [2:0] pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return OP_TICK;
    if (r < 50) return OP_SERVICE;
    if (r < 68) return OP_START;
    if (r < 78) return OP_CREATE;
    if (r < 88) return OP_STOP;
    if (r < 96) return OP_CHANGE;
    if (r < 98) return OP_RSVD_LO;
    return OP_RSVD_HI;
  endfunction

  task automatic send_req(input logic [2:0] op, input logic [2:0] id, input logic [15:0] per);
    req_t r;
    int   gap;
    r.opcode  = op;
    r.task_id = id;
    r.period  = per;
    start <= 1'b1;
    req_i <= r;
    while (busy) @(negedge clk_i);
    @(negedge clk_i);
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(negedge clk_i);
    while (outstanding != 0) @(negedge clk_i);
  endtask

  initial begin
    rst_ni = 1'b0;
    start  = 1'b0;
    req_i  = '0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_req(OP_SERVICE, 3'd0, 16'h0000);
    send_req(OP_TICK,    3'd0, 16'h0000);
    send_req(OP_CREATE,  3'd0, 16'h0000);
    send_req(OP_CREATE,  3'd7, 16'hFFFF);
    send_req(OP_CREATE,  3'd3, 16'h0002);
    send_req(OP_START,   3'd0, 16'h0000);
    send_req(OP_START,   3'd7, 16'h0000);
    send_req(OP_START,   3'd3, 16'h0000);
    send_req(OP_START,   3'd0, 16'hFFFF);
    send_req(OP_TICK,    3'd0, 16'h0000);
    send_req(OP_TICK,    3'd0, 16'h0000);
    send_req(OP_TICK,    3'd0, 16'h0000);
    send_req(OP_SERVICE, 3'd0, 16'h0000);
    send_req(OP_CHANGE,  3'd7, 16'h0000);
    send_req(OP_TICK,    3'd0, 16'h0000);
    send_req(OP_SERVICE, 3'd0, 16'h0000);
    send_req(OP_STOP,    3'd3, 16'h0000);
    send_req(OP_STOP,    3'd3, 16'h0000);
    send_req(OP_STOP,    3'd5, 16'h0000);
    send_req(OP_CREATE,  3'd0, 16'h0001);
    send_req(OP_RSVD_LO, 3'd7, 16'hFFFF);
    send_req(OP_RSVD_HI, 3'd2, 16'h5A5A);
    send_req(OP_CHANGE,  3'd5, 16'hA5A5);
    send_req(OP_SERVICE, 3'd0, 16'h0000);

    for (int k = 0; k < 200; k++) begin
      if (k == 100) begin
        drain();
        for (int id = 0; id < NUM_TASKS; id++) begin
          send_req(OP_CREATE, 3'(id), 16'h0000);
          send_req(OP_START, 3'(id), 16'h0000);
        end
        send_req(OP_TICK, 3'd0, 16'h0000);
        send_req(OP_SERVICE, 3'd0, 16'h0000);
      end
      send_req(pick_op(), 3'($urandom_range(0, 7)), pick_period());
    end

    drain();
    repeat (20) @(negedge clk_i);
    if (errors == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/ptts_pkg.sv
design/ptts_ram.sv
design/periodic_task_tick_scheduler.sv
test/sched_rsp_checker.sv
test/tb_periodic_task_tick_scheduler.sv
